>>> hdl/nft_pkg.sv
// Shared types, element codes and decode helpers for the numeric format tokenizer.
// No dependencies; every other file except nft_if.sv imports this package.
package nft_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [4:0] EL_DOLLAR = 5'd0;
  localparam logic [4:0] EL_ZERO   = 5'd1;
  localparam logic [4:0] EL_NINE   = 5'd2;
  localparam logic [4:0] EL_X      = 5'd3;
  localparam logic [4:0] EL_DOT    = 5'd4;
  localparam logic [4:0] EL_COMMA  = 5'd5;
  localparam logic [4:0] EL_S      = 5'd6;
  localparam logic [4:0] EL_MI     = 5'd7;
  localparam logic [4:0] EL_PR     = 5'd8;
  localparam logic [4:0] EL_RN     = 5'd9;
  localparam logic [4:0] EL_EEEE   = 5'd10;
  localparam logic [4:0] EL_B      = 5'd11;
  localparam logic [4:0] EL_V      = 5'd12;
  localparam logic [4:0] EL_FM     = 5'd13;
  localparam logic [4:0] EL_TM9    = 5'd14;
  localparam logic [4:0] EL_TME    = 5'd15;
  localparam logic [4:0] EL_TM     = 5'd16;
  localparam logic [4:0] EL_C      = 5'd17;
  localparam logic [4:0] EL_L      = 5'd18;
  localparam logic [4:0] EL_D      = 5'd19;
  localparam logic [4:0] EL_G      = 5'd20;

  localparam int NUM_ELEMENTS = 21;

  localparam logic [NUM_ELEMENTS-1:0] REPEATABLE =
      (NUM_ELEMENTS'(1) << EL_ZERO) | (NUM_ELEMENTS'(1) << EL_NINE) |
      (NUM_ELEMENTS'(1) << EL_X) | (NUM_ELEMENTS'(1) << EL_COMMA) |
      (NUM_ELEMENTS'(1) << EL_G);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_REPEAT  = 2'd2;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_M    = 3'd1,
    K_P    = 3'd2,
    K_R    = 3'd3,
    K_E    = 3'd4,
    K_F    = 3'd5,
    K_T    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ACT_EMIT,
    ACT_PEND,
    ACT_FAIL
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [4:0] code;
    logic       case_sens;
    kind_t      kind;
  } sdec_t;

  typedef struct packed {
    logic       is_token;
    logic [4:0] element_code;
    logic       upcase;
    logic       end_of_string;
    logic [1:0] status;
    logic [7:0] bad_char;
    logic [4:0] repeated_code;
  } res_t;

  // One queue entry holds all results of one character.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic [NUM_ELEMENTS-1:0] seen;
    logic                    found;
    logic [4:0]              code;
  } rep_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] second_char(input kind_t k);
    unique case (k)
      K_M:     return "I";
      K_P:     return "R";
      K_R:     return "N";
      K_E:     return "E";
      K_F:     return "M";
      K_T:     return "M";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [4:0] kind_code(input kind_t k);
    unique case (k)
      K_M:     return EL_MI;
      K_P:     return EL_PR;
      K_R:     return EL_RN;
      K_E:     return EL_EEEE;
      K_F:     return EL_FM;
      K_T:     return EL_TM;
      default: return EL_DOLLAR;
    endcase
  endfunction

  function automatic sdec_t start_dec(input logic [7:0] u);
    sdec_t d;
    d.act       = ACT_EMIT;
    d.code      = EL_DOLLAR;
    d.case_sens = 1'b1;
    d.kind      = K_NONE;
    unique case (u)
      "$": begin d.code = EL_DOLLAR; d.case_sens = 1'b0; end
      "0": begin d.code = EL_ZERO;   d.case_sens = 1'b0; end
      "9": begin d.code = EL_NINE;   d.case_sens = 1'b0; end
      ".": begin d.code = EL_DOT;    d.case_sens = 1'b0; end
      ",": begin d.code = EL_COMMA;  d.case_sens = 1'b0; end
      "X": d.code = EL_X;
      "S": d.code = EL_S;
      "B": d.code = EL_B;
      "V": d.code = EL_V;
      "C": d.code = EL_C;
      "L": d.code = EL_L;
      "D": d.code = EL_D;
      "G": d.code = EL_G;
      "M": begin d.act = ACT_PEND; d.kind = K_M; end
      "P": begin d.act = ACT_PEND; d.kind = K_P; end
      "R": begin d.act = ACT_PEND; d.kind = K_R; end
      "E": begin d.act = ACT_PEND; d.kind = K_E; end
      "F": begin d.act = ACT_PEND; d.kind = K_F; end
      "T": begin d.act = ACT_PEND; d.kind = K_T; end
      default: d.act = ACT_FAIL;
    endcase
    return d;
  endfunction

  function automatic rep_t note_code(input rep_t s, input logic [4:0] code);
    rep_t r;
    r = s;
    if (!REPEATABLE[code]) begin
      if (s.seen[code] && !s.found) begin
        r.found = 1'b1;
        r.code  = code;
      end
      r.seen[code] = 1'b1;
    end
    return r;
  endfunction

  function automatic res_t make_token(input logic [4:0] code, input logic up);
    res_t r;
    r              = '0;
    r.is_token     = 1'b1;
    r.element_code = code;
    r.upcase       = up;
    return r;
  endfunction

endpackage

>>> hdl/nft_if.sv
// Valid/ready channel interfaces for the tokenizer's character input and result output.
// Depends on nothing.
interface nft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source(output valid, output char_in, output last_char, input ready);
  modport sink(input valid, input char_in, input last_char, output ready);
endinterface

interface nft_out_if;
  logic       valid;
  logic       ready;
  logic       is_token;
  logic [4:0] element_code;
  logic       upcase;
  logic       end_of_string;
  logic [1:0] status;
  logic [7:0] bad_char;
  logic [4:0] repeated_code;

  modport source(output valid, output is_token, output element_code, output upcase,
                 output end_of_string, output status, output bad_char,
                 output repeated_code, input ready);
  modport sink(input valid, input is_token, input element_code, input upcase,
               input end_of_string, input status, input bad_char,
               input repeated_code, output ready);
endinterface

>>> hdl/numeric_format_tokenizer_core.sv
// Numeric format string tokenizer, top level: front end, entry queue, result serializer.
// Depends on nft_pkg, nft_if, nft_front, nft_queue and nft_back.
//
// One format-string character is accepted per cycle while the entry queue has room; the
// front end decides each character in the cycle it is taken. Results leave one word per
// cycle from the serializer while out_ch.ready is high, so a character that yields two
// words (a pending TM closed by a new element, or a last character that needs a separate
// end word) holds the output for both words; the DEPTH-entry queue absorbs these and
// any output stall. Result words are read from the registered queue head. No clearing pass after reset.
module numeric_format_tokenizer_core
  import nft_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input logic clk,
  input logic rst_n,
  nft_in_if.sink    in_ch,
  nft_out_if.source out_ch
);

  logic   accept, push, pop, full, empty;
  entry_t entry, head;
  res_t   res;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  nft_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .char_in  (in_ch.char_in),
    .last_char(in_ch.last_char),
    .push     (push),
    .entry    (entry)
  );

  nft_queue #(.DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(entry),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  nft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .head     (head),
    .out_ready(out_ch.ready),
    .pop      (pop),
    .out_valid(out_ch.valid),
    .out_res  (res)
  );

  assign out_ch.is_token      = res.is_token;
  assign out_ch.element_code  = res.element_code;
  assign out_ch.upcase        = res.upcase;
  assign out_ch.end_of_string = res.end_of_string;
  assign out_ch.status        = res.status;
  assign out_ch.bad_char      = res.bad_char;
  assign out_ch.repeated_code = res.repeated_code;

endmodule

>>> hdl/nft_front.sv
// Front end: per-character element matching, pending-prefix and string status state.
// Depends on nft_pkg. Produces one queue entry per character that yields results.
module nft_front
  import nft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       last_char,
  output logic       push,
  output entry_t     entry
);

  kind_t      pend_kind_r, pend_kind_nxt;
  logic [1:0] pend_cnt_r, pend_cnt_nxt;
  logic       pend_up_r, pend_up_nxt;
  logic [7:0] pend_char_r, pend_char_nxt;
  rep_t       rep_r, rep_nxt;
  logic       failed_r, failed_nxt;
  logic [7:0] fail_char_r, fail_char_nxt;

  logic [7:0] u;
  logic       up_c;
  logic       consumed;
  logic       e1_v, e2_v;
  res_t       t1, t2, r0, r1;
  logic [1:0] n;
  logic [1:0] st;
  sdec_t      sd;
  res_t       end_res;
  kind_t      pk;

  always_comb begin
    u    = fold(char_in);
    up_c = (char_in >= "A") && (char_in <= "Z");
    sd   = start_dec(u);

    pk            = pend_kind_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_up_nxt   = pend_up_r;
    pend_char_nxt = pend_char_r;
    rep_nxt       = rep_r;
    failed_nxt    = failed_r;
    fail_char_nxt = fail_char_r;
    consumed      = 1'b0;
    e1_v          = 1'b0;
    e2_v          = 1'b0;
    t1            = '0;
    t2            = '0;

    if (!failed_r) begin
      if (pend_kind_r != K_NONE) begin
        consumed = 1'b1;
        if (pend_kind_r == K_E) begin
          if (u == "E") begin
            if (pend_cnt_r == 2'd3) begin
              pk           = K_NONE;
              pend_cnt_nxt = 2'd0;
              e1_v         = 1'b1;
              t1           = make_token(EL_EEEE, pend_up_r);
            end else begin
              pend_cnt_nxt = pend_cnt_r + 2'd1;
            end
          end else begin
            failed_nxt    = 1'b1;
            fail_char_nxt = pend_char_r;
            pk            = K_NONE;
            pend_cnt_nxt  = 2'd0;
          end
        end else if (pend_kind_r == K_T && pend_cnt_r >= 2'd2) begin
          pk           = K_NONE;
          pend_cnt_nxt = 2'd0;
          e1_v         = 1'b1;
          if (char_in == "9") begin
            t1 = make_token(EL_TM9, pend_up_r);
          end else if (u == "E") begin
            t1 = make_token(EL_TME, pend_up_r);
          end else begin
            t1       = make_token(EL_TM, pend_up_r);
            consumed = 1'b0;
          end
        end else if (u == second_char(pend_kind_r)) begin
          if (pend_kind_r == K_T) begin
            pend_cnt_nxt = 2'd2;
          end else begin
            pk           = K_NONE;
            pend_cnt_nxt = 2'd0;
            e1_v         = 1'b1;
            t1           = make_token(kind_code(pend_kind_r), pend_up_r);
          end
        end else begin
          failed_nxt    = 1'b1;
          fail_char_nxt = pend_char_r;
          pk            = K_NONE;
          pend_cnt_nxt  = 2'd0;
        end
      end

      if (e1_v) begin
        rep_nxt = note_code(rep_nxt, t1.element_code);
      end

      if (!consumed && !failed_nxt) begin
        unique case (sd.act)
          ACT_EMIT: begin
            e2_v = 1'b1;
            t2   = make_token(sd.code, sd.case_sens & up_c);
          end
          ACT_PEND: begin
            pk            = sd.kind;
            pend_cnt_nxt  = 2'd1;
            pend_up_nxt   = up_c;
            pend_char_nxt = char_in;
          end
          default: begin
            failed_nxt    = 1'b1;
            fail_char_nxt = char_in;
            pk            = K_NONE;
            pend_cnt_nxt  = 2'd0;
          end
        endcase
      end

      if (last_char && !failed_nxt && pk != K_NONE) begin
        if (pk == K_T && pend_cnt_nxt >= 2'd2) begin
          pk           = K_NONE;
          pend_cnt_nxt = 2'd0;
          e2_v         = 1'b1;
          t2           = make_token(EL_TM, pend_up_nxt);
        end else begin
          failed_nxt    = 1'b1;
          fail_char_nxt = pend_char_nxt;
          pk            = K_NONE;
          pend_cnt_nxt  = 2'd0;
        end
      end

      if (e2_v) begin
        rep_nxt = note_code(rep_nxt, t2.element_code);
      end
    end
    pend_kind_nxt = pk;

    // pack results in emission order
    n  = {1'b0, e1_v} + {1'b0, e2_v};
    r0 = e1_v ? t1 : t2;
    r1 = t2;

    st = failed_nxt ? ST_INVALID : (rep_nxt.found ? ST_REPEAT : ST_OK);
    end_res               = '0;
    end_res.end_of_string = 1'b1;
    end_res.status        = st;
    end_res.bad_char      = (st == ST_INVALID) ? fail_char_nxt : 8'd0;
    end_res.repeated_code = (st == ST_REPEAT) ? rep_nxt.code : 5'd0;

    if (last_char) begin
      if (n != 2'd0 && !failed_nxt) begin
        if (n == 2'd2) begin
          r1.end_of_string = 1'b1;
          r1.status        = end_res.status;
          r1.bad_char      = end_res.bad_char;
          r1.repeated_code = end_res.repeated_code;
        end else begin
          r0.end_of_string = 1'b1;
          r0.status        = end_res.status;
          r0.bad_char      = end_res.bad_char;
          r0.repeated_code = end_res.repeated_code;
        end
      end else if (n == 2'd0) begin
        r0 = end_res;
        n  = 2'd1;
      end else begin
        r1 = end_res;
        n  = 2'd2;
      end
    end

    entry.two = (n == 2'd2);
    entry.r0  = r0;
    entry.r1  = r1;
    push      = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_kind_r <= K_NONE;
      pend_cnt_r  <= '0;
      pend_up_r   <= 1'b0;
      pend_char_r <= '0;
      rep_r       <= '0;
      failed_r    <= 1'b0;
      fail_char_r <= '0;
    end else if (accept) begin
      if (last_char) begin
        pend_kind_r <= K_NONE;
        pend_cnt_r  <= '0;
        pend_up_r   <= 1'b0;
        pend_char_r <= '0;
        rep_r       <= '0;
        failed_r    <= 1'b0;
        fail_char_r <= '0;
      end else begin
        pend_kind_r <= pend_kind_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
        pend_up_r   <= pend_up_nxt;
        pend_char_r <= pend_char_nxt;
        rep_r       <= rep_nxt;
        failed_r    <= failed_nxt;
        fail_char_r <= fail_char_nxt;
      end
    end
  end

endmodule

>>> hdl/nft_queue.sv
// Small entry queue between the front end and the result serializer.
// Depends on nft_pkg for the entry type.
module nft_queue
  import nft_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/nft_back.sv
// Back end: serializes each queued entry into one or two result words.
// Depends on nft_pkg; reads the head of nft_queue.
module nft_back
  import nft_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   empty,
  input  entry_t head,
  input  logic   out_ready,
  output logic   pop,
  output logic   out_valid,
  output res_t   out_res
);

  logic sub_r;
  logic take;

  assign out_valid = !empty;
  assign out_res   = sub_r ? head.r1 : head.r0;
  assign take      = out_valid && out_ready;
  assign pop       = take && (sub_r || !head.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else if (take) begin
      sub_r <= !pop;
    end
  end

endmodule

>>> hdl/nft_checker.sv
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Depends on nft_pkg for status codes.
module nft_checker
  import nft_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_token,
  input logic [4:0] element_code,
  input logic       upcase,
  input logic       end_of_string,
  input logic [1:0] status,
  input logic [7:0] bad_char,
  input logic [4:0] repeated_code
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(element_code) &&
      $stable(is_token) && $stable(end_of_string) && $stable(status))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_non_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_token |-> element_code == 5'd0 && !upcase && end_of_string)
    else $error("non-token word carries element fields or is not an end word");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (end_of_string || (status == ST_OK)) &&
      ((status == ST_INVALID) || (bad_char == 8'd0)) &&
      ((status == ST_REPEAT) || (repeated_code == 5'd0)) &&
      (!is_token || (status != ST_INVALID)))
    else $error("status fields inconsistent");

endmodule

bind numeric_format_tokenizer_core nft_checker u_nft_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .is_token     (out_ch.is_token),
  .element_code (out_ch.element_code),
  .upcase       (out_ch.upcase),
  .end_of_string(out_ch.end_of_string),
  .status       (out_ch.status),
  .bad_char     (out_ch.bad_char),
  .repeated_code(out_ch.repeated_code)
);
